FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset.
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/qat_pkg.sv
// ----------------------------------------------------------------------------
// Quoted argument tokenizer package
// Types, character codes and helpers shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package qat_pkg;

    localparam int MAX_WORD_LEN = 256;
    localparam int WLEN_W       = $clog2(MAX_WORD_LEN + 1);
    localparam int WCNT_W       = 7;

    localparam logic [WCNT_W-1:0] MAX_WORDS_RESET = 7'd16;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [1:0] {
        MODE_BETWEEN = 2'd0,
        MODE_DQUOTE  = 2'd1,
        MODE_BARE    = 2'd2,
        MODE_SQUOTE  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_ESC  = 3'd1,
        ST_TOO_LONG = 3'd2,
        ST_OPEN_DQ  = 3'd3,
        ST_OPEN_SQ  = 3'd4,
        ST_RESIDUAL = 3'd5
    } t_status;

    typedef struct packed {
        t_mode              mode;
        logic               esc;
        logic [WLEN_W-1:0]  wlen;
        logic [WCNT_W-1:0]  wfound;
        logic               skip;
        t_status            err;
    } t_scan_state;

    localparam t_scan_state SCAN_STATE_RESET = '{
        mode:   MODE_BETWEEN,
        esc:    1'b0,
        wlen:   '0,
        wfound: '0,
        skip:   1'b0,
        err:    ST_OK
    };

    typedef struct packed {
        logic               char_valid;
        logic [7:0]         char_out;
        logic               word_end;
        logic               line_done;
        logic [WCNT_W-1:0]  word_count;
        t_status            line_status;
    } t_scan_result;

    // White space includes the line terminator.
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_NUL) || (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

FILE: hw/rtl/qat_scan.sv
// ----------------------------------------------------------------------------
// Tokenizer scan step
// Next line state and result for one byte, given the current line state.
// ----------------------------------------------------------------------------
module qat_scan (
    input  qat_pkg::t_scan_state                i_state,
    input  logic [7:0]                          i_char,
    input  logic [qat_pkg::WCNT_W-1:0]          i_max_words,
    output qat_pkg::t_scan_state                o_state,
    output qat_pkg::t_scan_result               o_result
);

    logic w_blank;
    logic w_emit;
    logic w_fin;
    logic w_halt;

    assign w_blank = qat_pkg::is_blank(i_char);

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        w_emit   = 1'b0;
        w_fin    = 1'b0;
        w_halt   = 1'b0;

        if (!i_state.skip) begin
            if (!i_state.esc && (i_char == qat_pkg::CH_BSLASH) &&
                (i_state.mode != qat_pkg::MODE_SQUOTE)) begin
                o_state.esc = 1'b1;
            end else begin
                case (i_state.mode)
                    qat_pkg::MODE_BETWEEN: begin
                        if (!w_blank) begin
                            // A comment starts even after a backslash.
                            if ((i_char == qat_pkg::CH_SEMI) ||
                                (i_char == qat_pkg::CH_HASH)) begin
                                o_state.skip = 1'b1;
                                w_halt       = 1'b1;
                            end else if (!i_state.esc && (i_char == qat_pkg::CH_DQUOTE)) begin
                                o_state.mode = qat_pkg::MODE_DQUOTE;
                            end else if (!i_state.esc && (i_char == qat_pkg::CH_SQUOTE)) begin
                                o_state.mode = qat_pkg::MODE_SQUOTE;
                            end else begin
                                w_emit       = 1'b1;
                                o_state.mode = qat_pkg::MODE_BARE;
                            end
                        end
                    end
                    qat_pkg::MODE_BARE: begin
                        if (!i_state.esc && w_blank) begin
                            w_fin = 1'b1;
                        end else begin
                            w_emit = (i_char != qat_pkg::CH_NUL);
                        end
                    end
                    qat_pkg::MODE_DQUOTE: begin
                        if (!i_state.esc && (i_char == qat_pkg::CH_DQUOTE)) begin
                            w_fin = 1'b1;
                        end else begin
                            w_emit = (i_char != qat_pkg::CH_NUL);
                        end
                    end
                    qat_pkg::MODE_SQUOTE: begin
                        if (i_char == qat_pkg::CH_SQUOTE) begin
                            w_fin = 1'b1;
                        end else begin
                            w_emit = (i_char != qat_pkg::CH_NUL);
                        end
                    end
                    default: begin
                    end
                endcase

                if (!w_halt) begin
                    if (w_fin) begin
                        o_state.mode      = qat_pkg::MODE_BETWEEN;
                        o_state.wlen      = '0;
                        o_state.wfound    = i_state.wfound + qat_pkg::WCNT_W'(1);
                        o_result.word_end = 1'b1;
                    end
                    // Only a backslash, a double quote or white space may be escaped.
                    if (i_state.esc && w_emit &&
                        !((i_char == qat_pkg::CH_BSLASH) ||
                          (i_char == qat_pkg::CH_DQUOTE) || w_blank)) begin
                        o_state.err  = qat_pkg::ST_BAD_ESC;
                        o_state.skip = 1'b1;
                        w_halt       = 1'b1;
                    end else begin
                        o_state.esc = 1'b0;
                    end
                end
            end

            if (!w_halt && w_emit) begin
                if (i_state.wlen >= qat_pkg::WLEN_W'(qat_pkg::MAX_WORD_LEN)) begin
                    o_state.err  = qat_pkg::ST_TOO_LONG;
                    o_state.skip = 1'b1;
                    w_halt       = 1'b1;
                end else begin
                    o_state.wlen        = i_state.wlen + qat_pkg::WLEN_W'(1);
                    o_result.char_valid = 1'b1;
                    o_result.char_out   = i_char;
                end
            end

            if (!w_halt && (o_state.wfound >= i_max_words)) begin
                o_state.skip = 1'b1;
            end
        end

        if (i_char == qat_pkg::CH_NUL) begin
            o_result.line_done = 1'b1;
            if (o_state.err != qat_pkg::ST_OK) begin
                o_result.line_status = o_state.err;
            end else begin
                case (o_state.mode)
                    qat_pkg::MODE_DQUOTE: o_result.line_status = qat_pkg::ST_OPEN_DQ;
                    qat_pkg::MODE_SQUOTE: o_result.line_status = qat_pkg::ST_OPEN_SQ;
                    qat_pkg::MODE_BARE:   o_result.line_status = qat_pkg::ST_RESIDUAL;
                    default:              o_result.word_count  = o_state.wfound;
                endcase
            end
            o_state = qat_pkg::SCAN_STATE_RESET;
        end
    end

endmodule

FILE: hw/rtl/quoted_argument_tokenizer.sv
// ----------------------------------------------------------------------------
// Quoted argument tokenizer
// Splits a byte stream into shell-style words, one byte per unstalled clock.
// ----------------------------------------------------------------------------
// Usage:
// Line bytes enter on the input channel (i_in_valid, o_in_stall, i_char_in),
// one byte per transfer; a zero byte ends the line. Every input byte yields
// exactly one result on the output channel (o_out_valid, i_out_stall): a word
// character after quote and escape removal, a word end mark, and on the
// terminator the line status and word count.
// A byte lands in the input register at its transfer; the scan step computes
// the result and the next line state from it, and the result register
// presents it. Throughput is one byte per clock while the receiver does not
// stall; the only loop is the line state update. When the receiver stalls,
// the result register holds its value, and the input register fills once
// more before o_in_stall rises, so no byte is lost. The user writes the word
// limit register with i_cfg_we and i_cfg_data only while the block is idle;
// the block itself does not enforce this. Synchronous reset empties both
// registers, clears the line state and sets the word limit to sixteen.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quoted_argument_tokenizer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [qat_pkg::WCNT_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_char_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_char_valid,
    output logic [7:0]                      o_char_out,
    output logic                            o_word_end,
    output logic                            o_line_done,
    output logic [qat_pkg::WCNT_W-1:0]      o_word_count,
    output logic [2:0]                      o_line_status
);

    logic [qat_pkg::WCNT_W-1:0] r_max_words;
    logic                       r_s1_valid;
    logic [7:0]                 r_s1_char;
    qat_pkg::t_scan_state       r_state;
    qat_pkg::t_scan_state       n_state;
    logic                       r_out_valid;
    qat_pkg::t_scan_result      r_out;
    qat_pkg::t_scan_result      n_result;

    logic w_out_adv;
    logic w_in_take;
    logic w_step;

    // The result register can take a new value when it is empty or its
    // current result is transferred in this cycle.
    assign w_out_adv  = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !w_out_adv;
    assign w_in_take  = i_in_valid && !o_in_stall;
    // A byte in the input register is scanned and retired this cycle.
    assign w_step     = r_s1_valid && w_out_adv;

    qat_scan u_scan (
        .i_state     (r_state),
        .i_char      (r_s1_char),
        .i_max_words (r_max_words),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_words <= qat_pkg::MAX_WORDS_RESET;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= qat_pkg::SCAN_STATE_RESET;
        end else begin
            if (i_cfg_we) begin
                r_max_words <= i_cfg_data;
            end
            if (!o_in_stall) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_out_adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (w_step) begin
                r_state <= n_state;
            end
        end
    end

    // Payload registers load only on a move and need no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_char <= i_char_in;
        end
        if (w_step) begin
            r_out <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_char_valid  = r_out.char_valid;
    assign o_char_out    = r_out.char_out;
    assign o_word_end    = r_out.word_end;
    assign o_line_done   = r_out.line_done;
    assign o_word_count  = r_out.word_count;
    assign o_line_status = r_out.line_status;

    // Count and status are only reported on the terminator.
    `ASSERT_CLK(a_count_only_on_done,
        (o_out_valid && !o_line_done) |->
            (o_word_count == '0 && o_line_status == qat_pkg::ST_OK))
    // An error status carries no word count.
    `ASSERT_CLK(a_no_count_on_error,
        (o_out_valid && o_line_status != qat_pkg::ST_OK) |-> (o_word_count == '0))
    // The terminator is never given out as a word character.
    `ASSERT_CLK(a_char_not_terminator,
        (o_out_valid && o_char_valid) |->
            (o_char_out != qat_pkg::CH_NUL && !o_line_done))
    // Retiring a terminator starts a fresh line.
    `ASSERT_CLK(a_line_cleared,
        (w_step && r_s1_char == qat_pkg::CH_NUL) |=>
            (r_state.wfound == '0 && !r_state.skip &&
             r_state.mode == qat_pkg::MODE_BETWEEN))
    // Reset leaves the result register empty and the default word limit.
    `ASSERT_ALWAYS(a_reset_state,
        !i_rst_n |=> (!o_out_valid && r_max_words == qat_pkg::MAX_WORDS_RESET))

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Quoted argument tokenizer testbench
// Feeds lines of bytes through the tokenizer under shifting flow control,
// predicts every result from its own model of the line scanner, and compares
// each output transfer field by field. The word limit register is changed
// between lines while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_cfg_we      = 1'b0;
    logic [qat_pkg::WCNT_W-1:0]  i_cfg_data    = '0;
    logic                        i_in_valid    = 1'b0;
    logic [7:0]                  i_char_in     = 8'h00;
    logic                        i_out_stall   = 1'b0;
    logic                        o_in_stall;
    logic                        o_out_valid;
    logic                        o_char_valid;
    logic [7:0]                  o_char_out;
    logic                        o_word_end;
    logic                        o_line_done;
    logic [qat_pkg::WCNT_W-1:0]  o_word_count;
    logic [2:0]                  o_line_status;

    // Flow control knobs, in percent of cycles.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int mismatch_count = 0;
    int bytes_sent     = 0;

    // Results predicted at input transfers, oldest first.
    qat_pkg::t_scan_result pending_results[$];

    // Predicted line state and the word limit register.
    qat_pkg::t_mode             ln_mode    = qat_pkg::MODE_BETWEEN;
    logic                       ln_esc     = 1'b0;
    int                         ln_wlen    = 0;
    logic [qat_pkg::WCNT_W-1:0] ln_words   = '0;
    logic                       ln_skip    = 1'b0;
    qat_pkg::t_status           ln_err     = qat_pkg::ST_OK;
    logic [qat_pkg::WCNT_W-1:0] word_limit = qat_pkg::MAX_WORDS_RESET;

    quoted_argument_tokenizer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_char_in     (i_char_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_char_valid  (o_char_valid),
        .o_char_out    (o_char_out),
        .o_word_end    (o_word_end),
        .o_line_done   (o_line_done),
        .o_word_count  (o_word_count),
        .o_line_status (o_line_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Line scanner prediction
    // ------------------------------------------------------------------------

    // Advances the predicted line state by one byte and returns the result
    // that the block must give for it.
    function automatic qat_pkg::t_scan_result scan_predict(input logic [7:0] c);
        qat_pkg::t_scan_result r;
        logic                  white;
        logic                  emit;
        logic                  closed;
        logic                  halted;
        r      = '0;
        emit   = 1'b0;
        closed = 1'b0;
        halted = 1'b0;
        // The terminator counts as white space.
        white  = (c == qat_pkg::CH_NUL) || (c == qat_pkg::CH_SPACE) ||
                 (c >= qat_pkg::CH_TAB && c <= qat_pkg::CH_CR);

        if (!ln_skip) begin
            if (!ln_esc && c == qat_pkg::CH_BSLASH && ln_mode != qat_pkg::MODE_SQUOTE) begin
                ln_esc = 1'b1;
            end else begin
                case (ln_mode)
                    qat_pkg::MODE_BETWEEN: begin
                        if (!white) begin
                            // A comment starts here even after a backslash.
                            if (c == qat_pkg::CH_SEMI || c == qat_pkg::CH_HASH) begin
                                ln_skip = 1'b1;
                                halted  = 1'b1;
                            end else if (!ln_esc && c == qat_pkg::CH_DQUOTE) begin
                                ln_mode = qat_pkg::MODE_DQUOTE;
                            end else if (!ln_esc && c == qat_pkg::CH_SQUOTE) begin
                                ln_mode = qat_pkg::MODE_SQUOTE;
                            end else begin
                                emit    = 1'b1;
                                ln_mode = qat_pkg::MODE_BARE;
                            end
                        end
                    end
                    qat_pkg::MODE_BARE: begin
                        if (!ln_esc && white) closed = 1'b1;
                        else emit = (c != qat_pkg::CH_NUL);
                    end
                    qat_pkg::MODE_DQUOTE: begin
                        if (!ln_esc && c == qat_pkg::CH_DQUOTE) closed = 1'b1;
                        else emit = (c != qat_pkg::CH_NUL);
                    end
                    default: begin
                        if (c == qat_pkg::CH_SQUOTE) closed = 1'b1;
                        else emit = (c != qat_pkg::CH_NUL);
                    end
                endcase

                if (!halted) begin
                    if (closed) begin
                        ln_mode    = qat_pkg::MODE_BETWEEN;
                        ln_wlen    = 0;
                        ln_words   = ln_words + 1'b1;
                        r.word_end = 1'b1;
                    end
                    // Only a backslash, a double quote or white space may be
                    // escaped; anything else poisons the line.
                    if (ln_esc && emit && !(c == qat_pkg::CH_BSLASH ||
                                            c == qat_pkg::CH_DQUOTE || white)) begin
                        ln_err  = qat_pkg::ST_BAD_ESC;
                        ln_skip = 1'b1;
                        halted  = 1'b1;
                    end else begin
                        ln_esc = 1'b0;
                    end
                end
            end

            if (!halted && emit) begin
                if (ln_wlen >= qat_pkg::MAX_WORD_LEN) begin
                    ln_err  = qat_pkg::ST_TOO_LONG;
                    ln_skip = 1'b1;
                    halted  = 1'b1;
                end else begin
                    ln_wlen      = ln_wlen + 1;
                    r.char_valid = 1'b1;
                    r.char_out   = c;
                end
            end

            if (!halted && ln_words >= word_limit) ln_skip = 1'b1;
        end

        if (c == qat_pkg::CH_NUL) begin
            r.line_done = 1'b1;
            if (ln_err != qat_pkg::ST_OK) r.line_status = ln_err;
            else if (ln_mode == qat_pkg::MODE_DQUOTE) r.line_status = qat_pkg::ST_OPEN_DQ;
            else if (ln_mode == qat_pkg::MODE_SQUOTE) r.line_status = qat_pkg::ST_OPEN_SQ;
            else if (ln_mode == qat_pkg::MODE_BARE) r.line_status = qat_pkg::ST_RESIDUAL;
            else r.word_count = ln_words;
            ln_mode  = qat_pkg::MODE_BETWEEN;
            ln_esc   = 1'b0;
            ln_wlen  = 0;
            ln_words = '0;
            ln_skip  = 1'b0;
            ln_err   = qat_pkg::ST_OK;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Presents one byte, waits for its transfer and records the prediction.
    // Valid stays high afterwards so that back-to-back bytes flow; whoever
    // stops sending lowers it in the step of the last transfer.
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_char_in  <= 8'($urandom_range(255));
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_in  <= c;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(scan_predict(c));
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    // Stops the input and waits until every predicted result has come out.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_word_limit(input logic [qat_pkg::WCNT_W-1:0] lim);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= lim;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        word_limit = lim;
    endtask

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        qat_pkg::t_scan_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transfer with no byte waiting for it");
            end else begin
                want = pending_results.pop_front();
                check_field("char_valid", 8'(o_char_valid), 8'(want.char_valid));
                check_field("char_out", o_char_out, want.char_out);
                check_field("word_end", 8'(o_word_end), 8'(want.word_end));
                check_field("line_done", 8'(o_line_done), 8'(want.line_done));
                check_field("word_count", 8'(o_word_count), 8'(want.word_count));
                check_field("line_status", 8'(o_line_status), 8'(want.line_status));
            end
        end
    end

    // Ends a hung run: counts cycles in which neither channel moves a transfer.
    always @(posedge i_clk) begin
        int quiet_cycles;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding",
                     pending_results.size());
            $display("quoted_argument_tokenizer test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Random line content
    // ------------------------------------------------------------------------

    function automatic logic [7:0] pick_blank();
        if ($urandom_range(3) == 0) return qat_pkg::CH_SPACE;
        return 8'($urandom_range(9, 13));
    endfunction

    // Any byte that has no meaning inside a bare word. The first byte of a
    // word also avoids quotes and comment starters.
    function automatic logic [7:0] pick_plain(input logic first);
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(1, 255));
        end while (c == qat_pkg::CH_SPACE ||
                   (c >= qat_pkg::CH_TAB && c <= qat_pkg::CH_CR) ||
                   c == qat_pkg::CH_BSLASH ||
                   (first && (c == qat_pkg::CH_DQUOTE || c == qat_pkg::CH_SQUOTE ||
                              c == qat_pkg::CH_SEMI || c == qat_pkg::CH_HASH)));
        return c;
    endfunction

    function automatic logic [7:0] pick_escapable();
        case ($urandom_range(3))
            0: return qat_pkg::CH_BSLASH;
            1: return qat_pkg::CH_DQUOTE;
            default: return pick_blank();
        endcase
    endfunction

    task automatic send_escaped_pair();
        send_char(qat_pkg::CH_BSLASH);
        send_char(pick_escapable());
    endtask

    // Mostly well-formed lines of bare and quoted words with random content;
    // a minority end in a comment, a bad escape, an open quote, a dangling backslash or raw noise.
    task automatic send_random_line();
        int         n_words;
        int         len;
        int         kind;
        logic [7:0] c;
        n_words = $urandom_range(0, 10);
        for (int w = 0; w < n_words; w++) begin
            repeat ($urandom_range(w == 0 ? 0 : 1, 2)) send_char(pick_blank());
            kind = $urandom_range(99);
            len  = $urandom_range(0, 6);
            if (kind < 50) begin
                send_char(pick_plain(1'b1));
                repeat (len) begin
                    if ($urandom_range(9) == 0) send_escaped_pair();
                    else send_char(pick_plain(1'b0));
                end
            end else if (kind < 75) begin
                send_char(qat_pkg::CH_DQUOTE);
                repeat (len) begin
                    if ($urandom_range(7) == 0) begin
                        send_escaped_pair();
                    end else begin
                        do c = 8'($urandom_range(1, 255));
                        while (c == qat_pkg::CH_DQUOTE || c == qat_pkg::CH_BSLASH);
                        send_char(c);
                    end
                end
                send_char(qat_pkg::CH_DQUOTE);
            end else if (kind < 92) begin
                // A backslash is an ordinary byte between single quotes.
                send_char(qat_pkg::CH_SQUOTE);
                repeat (len) begin
                    do c = 8'($urandom_range(1, 255)); while (c == qat_pkg::CH_SQUOTE);
                    send_char(c);
                end
                send_char(qat_pkg::CH_SQUOTE);
            end else begin
                repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(1, 255)));
            end
        end

        kind = $urandom_range(99);
        if (kind < 6) begin
            send_char(qat_pkg::CH_SPACE);
            send_char($urandom_range(1) ? qat_pkg::CH_SEMI : qat_pkg::CH_HASH);
            repeat ($urandom_range(0, 4)) send_char(8'($urandom_range(1, 255)));
        end else if (kind < 10) begin
            send_char(qat_pkg::CH_SPACE);
            send_char(pick_plain(1'b1));
            send_char(qat_pkg::CH_BSLASH);
            do c = 8'($urandom_range(1, 255));
            while (c == qat_pkg::CH_BSLASH || c == qat_pkg::CH_DQUOTE ||
                   c == qat_pkg::CH_SPACE ||
                   (c >= qat_pkg::CH_TAB && c <= qat_pkg::CH_CR));
            send_char(c);
        end else if (kind < 14) begin
            send_char(qat_pkg::CH_SPACE);
            send_char($urandom_range(1) ? qat_pkg::CH_DQUOTE : qat_pkg::CH_SQUOTE);
            repeat ($urandom_range(0, 3)) send_char(pick_plain(1'b0));
        end else if (kind < 17) begin
            send_char(qat_pkg::CH_SPACE);
            send_char(pick_plain(1'b1));
            send_char(qat_pkg::CH_BSLASH);
        end
        send_char(qat_pkg::CH_NUL);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // All kinds of white space, high and low bytes as word characters, and an
    // empty line.
    task automatic test_blanks_and_bytes();
        send_text("ab");
        send_char(qat_pkg::CH_TAB);
        send_char(8'h0B);
        send_char(8'h0C);
        send_char(qat_pkg::CH_CR);
        send_char(8'h0A);
        send_char(8'hFF);
        send_char(8'h80);
        send_char(qat_pkg::CH_SPACE);
        send_char(8'h01);
        send_char(8'h7F);
        send_char(qat_pkg::CH_NUL);
        send_char(qat_pkg::CH_NUL);
        drain();
    endtask

    // Double and single quoted words, an empty quoted word, quotes inside a
    // bare word, and both kinds of unclosed quote.
    task automatic test_quoting();
        send_text("\"a b\" 'c\\d' \"\" x\"y'");
        send_char(qat_pkg::CH_NUL);
        send_text("\"open");
        send_char(qat_pkg::CH_NUL);
        send_text("'open");
        send_char(qat_pkg::CH_NUL);
        drain();
    endtask

    // Legal escapes in every position, escapes that are not allowed, and an
    // escaped terminator inside a bare word and inside double quotes.
    task automatic test_escapes();
        send_text("a\\ b\\\"\\\\ \\\"q \"s\\\"t\\\\\"");
        send_char(qat_pkg::CH_NUL);
        send_text("\\ a");
        send_char(qat_pkg::CH_NUL);
        send_text("\\x");
        send_char(qat_pkg::CH_NUL);
        send_text("\\'");
        send_char(qat_pkg::CH_NUL);
        send_text("ab\\");
        send_char(qat_pkg::CH_NUL);
        send_text("\"a\\");
        send_char(qat_pkg::CH_NUL);
        send_text("\\;x y");
        send_char(qat_pkg::CH_NUL);
        drain();
    endtask

    // Comment starters end the line only between words.
    task automatic test_comments();
        send_text("a ;b c");
        send_char(qat_pkg::CH_NUL);
        send_text("#x");
        send_char(qat_pkg::CH_NUL);
        send_text("a#b 'c;'");
        send_char(qat_pkg::CH_NUL);
        drain();
    endtask

    // A word of exactly the maximum length passes; one more byte is an error.
    task automatic test_word_length();
        for (int extra = 0; extra < 2; extra++) begin
            repeat (qat_pkg::MAX_WORD_LEN + extra) send_char(pick_plain(1'b1));
            send_char(qat_pkg::CH_NUL);
        end
        drain();
    endtask

    // The word limit at both ends of its range, at zero and beyond 64.
    task automatic test_word_limits();
        set_word_limit(7'd1);
        send_text("a b c");
        send_char(qat_pkg::CH_NUL);

        // With a zero limit, whatever the first byte opens stays open.
        set_word_limit(7'd0);
        send_text("a");
        send_char(qat_pkg::CH_NUL);
        send_text("\"");
        send_char(qat_pkg::CH_NUL);
        send_text("'");
        send_char(qat_pkg::CH_NUL);
        send_text("  b");
        send_char(qat_pkg::CH_NUL);

        set_word_limit(7'd127);
        repeat (130) send_text("w ");
        send_char(qat_pkg::CH_NUL);

        set_word_limit(7'd64);
        repeat (66) send_text("w ");
        send_char(qat_pkg::CH_NUL);

        set_word_limit(qat_pkg::MAX_WORDS_RESET);
    endtask

    // Random lines, moving the word limit every few lines.
    task automatic test_random_lines(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(5) == 0) begin
                case ($urandom_range(9))
                    0: set_word_limit(7'd0);
                    1: set_word_limit(7'd1);
                    2: set_word_limit(7'd2);
                    3: set_word_limit(7'd3);
                    4: set_word_limit(7'd5);
                    5: set_word_limit(7'd8);
                    6: set_word_limit(qat_pkg::MAX_WORDS_RESET);
                    7: set_word_limit(7'd64);
                    8: set_word_limit(7'd127);
                    default: set_word_limit(7'($urandom_range(1, 64)));
                endcase
            end
            send_random_line();
        end
        drain();
    endtask

    initial begin
        send_idle_pct = 21;
        recv_idle_pct = 82;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_blanks_and_bytes();
        test_quoting();
        test_escapes();
        test_comments();
        test_word_length();
        test_word_limits();

        // The directed tests above send about a thousand bytes.
        test_random_lines(35);
        send_idle_pct = 82;
        recv_idle_pct = 21;
        test_random_lines(35);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_lines(35);

        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        if (mismatch_count == 0) begin
            $display("quoted_argument_tokenizer test passed");
        end else begin
            $display("quoted_argument_tokenizer test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/qat_pkg.sv
hw/rtl/qat_scan.sv
hw/rtl/quoted_argument_tokenizer.sv
dv/testbench.sv
